[hdl/lsf_pkg.sv]
// Shared types and constants for the least-squares line fit block.
// No dependencies.
package lsf_pkg;

	localparam int SAMPLE_BITS = 16;
	localparam int COUNT_BITS  = 16;
	localparam int FRAC_BITS   = 16;

	localparam int FQ_DEPTH = 4;
	localparam int WORD_W   = 64;
	localparam int STEP_W   = 7;

	localparam logic OP_ADD   = 1'b0;
	localparam logic OP_SOLVE = 1'b1;

	localparam logic [31:0] POS_LIMIT = 32'h7FFF_FFFF;
	localparam logic [31:0] NEG_LIMIT = 32'h8000_0000;

	typedef enum logic [3:0] {
		S_IDLE,
		S_M_NSX2,
		S_M_SXSX,
		S_CHECK,
		S_M_NSXY,
		S_M_SXSY,
		S_SIGN,
		S_D_SLOPE,
		S_M_ASX,
		S_D_INTC,
		S_EMIT
	} back_state_t;

endpackage

[hdl/least_squares_line_fit_top.sv]
// Top level of the least-squares line fit: front queue plus solve back end.
// Depends on lsf_pkg, lsf_front and lsf_back.
//
// Add-sample transactions (op 0) are absorbed at one per cycle: the back end
// folds one queued sample into the running sums in each cycle it is idle. A
// solve transaction (op 1) occupies the back end while it runs one shared
// 64-step shift-add multiplier and one restoring divider, of 64 + FRAC_BITS
// steps for the slope and 64 steps for the intercept; with fewer than two
// samples or all x equal it stops after the first two products. Up to four
// transactions queue in front while a solve runs. The result register holds
// one fit until popped; slope and intercept are signed Q16.16, truncated
// toward zero and saturated.
module least_squares_line_fit_top #(
	parameter int SAMPLE_BITS = lsf_pkg::SAMPLE_BITS,
	parameter int COUNT_BITS  = lsf_pkg::COUNT_BITS,
	parameter int FRAC_BITS   = lsf_pkg::FRAC_BITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  logic                          op,
	input  logic signed [SAMPLE_BITS-1:0] x_sample,
	input  logic signed [SAMPLE_BITS-1:0] y_sample,
	output logic                          empty,
	input  logic                          pop,
	output logic signed [31:0]            slope,
	output logic signed [31:0]            intercept,
	output logic                          converged
);

	logic                          q_valid;
	logic                          q_solve;
	logic signed [SAMPLE_BITS-1:0] q_x;
	logic signed [SAMPLE_BITS-1:0] q_y;
	logic                          q_pop;

	lsf_front #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.op       (op),
		.x_sample (x_sample),
		.y_sample (y_sample),
		.q_valid  (q_valid),
		.q_solve  (q_solve),
		.q_x      (q_x),
		.q_y      (q_y),
		.q_pop    (q_pop)
	);

	lsf_back #(
		.SAMPLE_BITS(SAMPLE_BITS),
		.COUNT_BITS (COUNT_BITS),
		.FRAC_BITS  (FRAC_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_solve   (q_solve),
		.q_x       (q_x),
		.q_y       (q_y),
		.q_pop     (q_pop),
		.empty     (empty),
		.pop       (pop),
		.slope     (slope),
		.intercept (intercept),
		.converged (converged)
	);

endmodule

[hdl/lsf_front.sv]
// Front end: accepts transactions into a short queue and marks solve requests.
// Depends on lsf_pkg.
module lsf_front #(
	parameter int SAMPLE_BITS = lsf_pkg::SAMPLE_BITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  logic                          op,
	input  logic signed [SAMPLE_BITS-1:0] x_sample,
	input  logic signed [SAMPLE_BITS-1:0] y_sample,
	output logic                          q_valid,
	output logic                          q_solve,
	output logic signed [SAMPLE_BITS-1:0] q_x,
	output logic signed [SAMPLE_BITS-1:0] q_y,
	input  logic                          q_pop
);

	localparam int PTR_W = $clog2(lsf_pkg::FQ_DEPTH);
	localparam int CNT_W = PTR_W + 1;

	logic                          solve_q [lsf_pkg::FQ_DEPTH];
	logic signed [SAMPLE_BITS-1:0] x_q     [lsf_pkg::FQ_DEPTH];
	logic signed [SAMPLE_BITS-1:0] y_q     [lsf_pkg::FQ_DEPTH];
	logic [PTR_W-1:0]              wptr_q;
	logic [PTR_W-1:0]              rptr_q;
	logic [CNT_W-1:0]              cnt_q;
	logic                          wr;
	logic                          rd;

	assign full    = (cnt_q == CNT_W'(lsf_pkg::FQ_DEPTH));
	assign q_valid = (cnt_q != '0);
	assign wr      = push && !full;
	assign rd      = q_pop && q_valid;
	assign q_solve = solve_q[rptr_q];
	assign q_x     = x_q[rptr_q];
	assign q_y     = y_q[rptr_q];

	always_ff @(posedge clk) begin
		if (wr) begin
			solve_q[wptr_q] <= (op == lsf_pkg::OP_SOLVE);
			x_q[wptr_q]     <= x_sample;
			y_q[wptr_q]     <= y_sample;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (wr) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (rd) begin
				rptr_q <= rptr_q + 1'b1;
			end
			if (wr && !rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (rd && !wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

[hdl/lsf_back.sv]
// Back end: running sums, solve sequencer with shared shift-add multiplier and
// restoring divider, and the result register. Depends on lsf_pkg.
module lsf_back #(
	parameter int SAMPLE_BITS = lsf_pkg::SAMPLE_BITS,
	parameter int COUNT_BITS  = lsf_pkg::COUNT_BITS,
	parameter int FRAC_BITS   = lsf_pkg::FRAC_BITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          q_valid,
	input  logic                          q_solve,
	input  logic signed [SAMPLE_BITS-1:0] q_x,
	input  logic signed [SAMPLE_BITS-1:0] q_y,
	output logic                          q_pop,
	output logic                          empty,
	input  logic                          pop,
	output logic signed [31:0]            slope,
	output logic signed [31:0]            intercept,
	output logic                          converged
);

	localparam int W      = lsf_pkg::WORD_W;
	localparam int SX_W   = SAMPLE_BITS + COUNT_BITS;
	localparam int P_W    = 2 * SAMPLE_BITS;
	localparam int SXY_W  = P_W + COUNT_BITS;
	localparam int SW     = lsf_pkg::STEP_W;
	localparam logic [SW-1:0] MUL_LAST   = SW'(W - 1);
	localparam logic [SW-1:0] SLOPE_LAST = SW'(W + FRAC_BITS - 1);
	localparam logic [SW-1:0] OVF_STEP   = SW'(W);
	localparam logic [W-1:0]  SLOPE_QMAX_POS = W'(lsf_pkg::POS_LIMIT >> FRAC_BITS);
	localparam logic [W-1:0]  SLOPE_QMAX_NEG = W'(lsf_pkg::NEG_LIMIT >> FRAC_BITS);

	lsf_pkg::back_state_t state_q, state_nx;

	logic [COUNT_BITS-1:0]   n_q;
	logic signed [SX_W-1:0]  sx_q;
	logic signed [SX_W-1:0]  sy_q;
	logic signed [SXY_W-1:0] sxy_q;
	logic signed [SXY_W-1:0] sxx_q;
	logic [31:0]             slope_q;
	logic [31:0]             intc_q;
	logic                    fit_q;

	logic [W-1:0]  mc_q, mp_q, acc_q, t_q, den_q, num_q;
	logic [W-1:0]  rem_q, dvd_q, quo_q, dsr_q;
	logic [SW-1:0] step_q;
	logic          neg_q, ovf_q;
	logic [31:0]   a_q;

	logic          out_v_q;
	logic [31:0]   out_slope_q, out_intc_q;
	logic          out_conv_q;

	logic signed [P_W-1:0] pxy, pxx;
	logic [W-1:0]  prod;
	logic [W:0]    cand;
	logic          ge;
	logic [W-1:0]  rem_nx, quo_nx;
	logic          mul_last, slope_last, intc_last;
	logic          out_free;
	logic [W-1:0]  n64, sx64, sy64, sxy64, sxx64;
	logic [W-1:0]  num_adj, den_adj, b_val;
	logic [31:0]   slope_mag, intc_mag, slope_res;

	assign n64   = W'(n_q);
	assign sx64  = W'(sx_q);
	assign sy64  = W'(sy_q);
	assign sxy64 = W'(sxy_q);
	assign sxx64 = W'(sxx_q);

	assign pxy = q_x * q_y;
	assign pxx = q_x * q_x;

	assign prod = acc_q + (mp_q[0] ? mc_q : '0);

	assign cand   = {rem_q, dvd_q[W-1]};
	assign ge     = (cand >= {1'b0, dsr_q});
	assign rem_nx = ge ? W'(cand - {1'b0, dsr_q}) : cand[W-1:0];
	assign quo_nx = {quo_q[W-2:0], ge};

	assign mul_last   = (step_q == MUL_LAST);
	assign slope_last = (step_q == SLOPE_LAST);
	assign intc_last  = (step_q == MUL_LAST);

	assign num_adj = den_q[W-1] ? (W'(0) - num_q) : num_q;
	assign den_adj = den_q[W-1] ? (W'(0) - den_q) : den_q;
	assign b_val   = (sy64 << FRAC_BITS) - prod;

	assign slope_mag = (ovf_q || quo_nx > W'(neg_q ? lsf_pkg::NEG_LIMIT : lsf_pkg::POS_LIMIT))
		? (neg_q ? lsf_pkg::NEG_LIMIT : lsf_pkg::POS_LIMIT) : quo_nx[31:0];
	assign intc_mag = (quo_nx > W'(neg_q ? lsf_pkg::NEG_LIMIT : lsf_pkg::POS_LIMIT))
		? (neg_q ? lsf_pkg::NEG_LIMIT : lsf_pkg::POS_LIMIT) : quo_nx[31:0];
	assign slope_res = neg_q ? (32'd0 - slope_mag) : slope_mag;

	assign out_free  = !out_v_q || pop;
	assign empty     = !out_v_q;
	assign slope     = out_slope_q;
	assign intercept = out_intc_q;
	assign converged = out_conv_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lsf_pkg::S_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		q_pop    = 1'b0;
		unique case (state_q)
			lsf_pkg::S_IDLE: begin
				q_pop = q_valid;
				if (q_valid && q_solve) begin
					state_nx = lsf_pkg::S_M_NSX2;
				end
			end
			lsf_pkg::S_M_NSX2: if (mul_last) state_nx = lsf_pkg::S_M_SXSX;
			lsf_pkg::S_M_SXSX: if (mul_last) state_nx = lsf_pkg::S_CHECK;
			lsf_pkg::S_CHECK: begin
				if (n_q < COUNT_BITS'(2) || den_q == '0) begin
					state_nx = lsf_pkg::S_EMIT;
				end else begin
					state_nx = lsf_pkg::S_M_NSXY;
				end
			end
			lsf_pkg::S_M_NSXY: if (mul_last) state_nx = lsf_pkg::S_M_SXSY;
			lsf_pkg::S_M_SXSY: if (mul_last) state_nx = lsf_pkg::S_SIGN;
			lsf_pkg::S_SIGN:    state_nx = lsf_pkg::S_D_SLOPE;
			lsf_pkg::S_D_SLOPE: if (slope_last) state_nx = lsf_pkg::S_M_ASX;
			lsf_pkg::S_M_ASX:   if (mul_last) state_nx = lsf_pkg::S_D_INTC;
			lsf_pkg::S_D_INTC:  if (intc_last) state_nx = lsf_pkg::S_EMIT;
			lsf_pkg::S_EMIT:    if (out_free) state_nx = lsf_pkg::S_IDLE;
			default:            state_nx = lsf_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q        <= '0;
			sx_q       <= '0;
			sy_q       <= '0;
			sxy_q      <= '0;
			sxx_q      <= '0;
			slope_q    <= '0;
			intc_q     <= '0;
			fit_q      <= 1'b0;
			out_v_q    <= 1'b0;
			step_q     <= '0;
		end else begin
			if (pop && out_v_q) begin
				out_v_q <= 1'b0;
			end
			unique case (state_q)
				lsf_pkg::S_IDLE: begin
					step_q <= '0;
					if (q_valid && !q_solve && n_q != '1) begin
						n_q   <= n_q + 1'b1;
						sx_q  <= sx_q + SX_W'(q_x);
						sy_q  <= sy_q + SX_W'(q_y);
						sxy_q <= sxy_q + SXY_W'(pxy);
						sxx_q <= sxx_q + SXY_W'(pxx);
					end
				end
				lsf_pkg::S_M_NSX2, lsf_pkg::S_M_SXSX, lsf_pkg::S_M_NSXY,
				lsf_pkg::S_M_SXSY, lsf_pkg::S_M_ASX: begin
					step_q <= mul_last ? '0 : step_q + 1'b1;
				end
				lsf_pkg::S_CHECK: begin
					step_q <= '0;
					if (n_q < COUNT_BITS'(2) || den_q == '0) begin
						fit_q <= 1'b0;
					end
				end
				lsf_pkg::S_SIGN: begin
					step_q <= '0;
				end
				lsf_pkg::S_D_SLOPE: begin
					step_q <= slope_last ? '0 : step_q + 1'b1;
				end
				lsf_pkg::S_D_INTC: begin
					step_q <= intc_last ? '0 : step_q + 1'b1;
					if (intc_last) begin
						slope_q <= a_q;
						intc_q  <= neg_q ? (32'd0 - intc_mag) : intc_mag;
						fit_q   <= 1'b1;
					end
				end
				lsf_pkg::S_EMIT: begin
					if (out_free) begin
						out_v_q <= 1'b1;
					end
				end
				default: begin
					step_q <= '0;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			lsf_pkg::S_IDLE: begin
				mc_q  <= sxx64;
				mp_q  <= n64;
				acc_q <= '0;
			end
			lsf_pkg::S_M_NSX2, lsf_pkg::S_M_SXSX, lsf_pkg::S_M_NSXY,
			lsf_pkg::S_M_SXSY, lsf_pkg::S_M_ASX: begin
				acc_q <= prod;
				mc_q  <= mc_q << 1;
				mp_q  <= mp_q >> 1;
				if (mul_last) begin
					acc_q <= '0;
					unique case (state_q)
						lsf_pkg::S_M_NSX2: begin
							t_q  <= prod;
							mc_q <= sx64;
							mp_q <= sx64;
						end
						lsf_pkg::S_M_SXSX: begin
							den_q <= t_q - prod;
						end
						lsf_pkg::S_M_NSXY: begin
							t_q  <= prod;
							mc_q <= sy64;
							mp_q <= sx64;
						end
						lsf_pkg::S_M_SXSY: begin
							num_q <= t_q - prod;
						end
						default: begin
							neg_q <= b_val[W-1];
							dvd_q <= b_val[W-1] ? (W'(0) - b_val) : b_val;
							dsr_q <= n64;
							rem_q <= '0;
							quo_q <= '0;
						end
					endcase
				end
			end
			lsf_pkg::S_CHECK: begin
				mc_q  <= sxy64;
				mp_q  <= n64;
				acc_q <= '0;
			end
			lsf_pkg::S_SIGN: begin
				neg_q <= num_adj[W-1];
				dvd_q <= num_adj[W-1] ? (W'(0) - num_adj) : num_adj;
				dsr_q <= den_adj;
				rem_q <= '0;
				quo_q <= '0;
				ovf_q <= 1'b0;
			end
			lsf_pkg::S_D_SLOPE, lsf_pkg::S_D_INTC: begin
				rem_q <= rem_nx;
				quo_q <= quo_nx;
				dvd_q <= dvd_q << 1;
				if (state_q == lsf_pkg::S_D_SLOPE) begin
					if (step_q == OVF_STEP &&
						quo_q > (neg_q ? SLOPE_QMAX_NEG : SLOPE_QMAX_POS)) begin
						ovf_q <= 1'b1;
					end
					if (slope_last) begin
						a_q   <= slope_res;
						mc_q  <= W'(signed'(slope_res));
						mp_q  <= sx64;
						acc_q <= '0;
					end
				end
			end
			lsf_pkg::S_EMIT: begin
				if (out_free) begin
					out_slope_q <= slope_q;
					out_intc_q  <= intc_q;
					out_conv_q  <= fit_q;
				end
			end
			default: begin
				acc_q <= '0;
			end
		endcase
	end

endmodule
